FILE: hw/rtl/page_table_walk_macros.svh
// ----------------------------------------------------------------------------
// page_table_walk_macros: assertion helpers for the page table walker
// All checks sample on the rising edge of clk and are off while rst is high.
// ----------------------------------------------------------------------------
`ifndef PAGE_TABLE_WALK_MACROS_SVH
`define PAGE_TABLE_WALK_MACROS_SVH

// Check that a property holds at every clock edge.
`define PTW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds.
`define PTW_NEVER(label, cond, msg) \
  `PTW_ASSERT(label, !(cond), msg)

`endif

FILE: hw/rtl/ptw_pkg.sv
// ----------------------------------------------------------------------------
// ptw_pkg
// Types and constants shared by the page table walker modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptw_pkg;

  // Input word: a table write or a translate request.
  typedef struct packed {
    logic        mode;
    logic [11:0] entry_index;
    logic [63:0] entry_value;
    logic [63:0] virt_addr;
  } in_word_t;

  // Result word of a translate request.
  typedef struct packed {
    logic [52:0] phys_addr;
    logic [1:0]  status;
    logic [1:0]  page_size;
  } out_word_t;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_WALK  = 1'b1;

  localparam logic [1:0] ST_MAPPED       = 2'd0;
  localparam logic [1:0] ST_NOT_PRESENT  = 2'd1;
  localparam logic [1:0] ST_OUT_OF_RANGE = 2'd2;

  localparam logic [1:0] PS_4K = 2'd0;
  localparam logic [1:0] PS_2M = 2'd1;
  localparam logic [1:0] PS_1G = 2'd2;

  localparam logic [1:0] LVL_PML4 = 2'd0;
  localparam logic [1:0] LVL_PDPT = 2'd1;
  localparam logic [1:0] LVL_PD   = 2'd2;
  localparam logic [1:0] LVL_PT   = 2'd3;

  localparam int unsigned BIT_PRESENT     = 0;
  localparam int unsigned BIT_LARGE       = 7;
  localparam int unsigned WORDS_PER_TABLE = 512;

  // Command queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    CMD_WRITE,
    CMD_WALK
  } cmd_t;

  // data is the entry word for a write, the virtual address for a walk.
  typedef struct packed {
    cmd_t        cmd;
    logic [11:0] index;
    logic [63:0] data;
  } q_entry_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EVAL
  } bk_state_t;

endpackage

FILE: hw/rtl/ptw_ram.sv
// ----------------------------------------------------------------------------
// ptw_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // Read data holds while re is low.
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/ptw_front.sv
// ----------------------------------------------------------------------------
// ptw_front
// Accept input words, classify them and push commands into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptw_front
  import ptw_pkg::*;
#(
  parameter int unsigned TABLE_WORDS = 4096
) (
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_word,
  input  logic     q_full,
  input  logic     clearing,
  output logic     push,
  output q_entry_t push_entry
);

  logic accept;
  logic write_hit;

  // Hold off new words while the queue is full or the store is being cleared.
  assign in_stall = q_full || clearing;
  assign accept   = in_valid && !in_stall;

  // Drop writes that fall beyond the store.
  assign write_hit = 32'(in_word.entry_index) < 32'(TABLE_WORDS);

  always_comb begin
    push             = 1'b0;
    push_entry.cmd   = CMD_WRITE;
    push_entry.index = in_word.entry_index;
    push_entry.data  = in_word.entry_value;
    if (in_word.mode == MODE_WALK) begin
      push_entry.cmd  = CMD_WALK;
      push_entry.data = in_word.virt_addr;
      push            = accept;
    end else begin
      push = accept && write_hit;
    end
  end

endmodule

FILE: hw/rtl/ptw_queue.sv
// ----------------------------------------------------------------------------
// ptw_queue
// Short command FIFO between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptw_queue
  import ptw_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_entry,
  input  logic     pop,
  output logic     full,
  output logic     head_valid,
  output q_entry_t head
);

  q_entry_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

FILE: hw/rtl/ptw_back.sv
// ----------------------------------------------------------------------------
// ptw_back
// Clear the table store, apply writes and walk the tables, one command at a
// time, into a registered result slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "page_table_walk_macros.svh"

module ptw_back
  import ptw_pkg::*;
#(
  parameter int unsigned TABLE_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [35:0] root_base,
  input  logic        head_valid,
  input  q_entry_t    head,
  output logic        pop,
  output logic        clearing,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word
);

  localparam int unsigned AW       = $clog2(TABLE_WORDS);
  localparam int unsigned MAX_BASE = (TABLE_WORDS - WORDS_PER_TABLE) / WORDS_PER_TABLE;

  bk_state_t   state;
  bk_state_t   state_next;
  logic [AW-1:0] clr_cnt;
  logic [1:0]  level;
  logic [1:0]  level_next;
  logic [47:0] va;
  logic        va_load;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [63:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [63:0]   ram_rdata;

  logic        out_free;
  logic        out_load;
  out_word_t   out_next;

  logic        root_ok;
  logic [35:0] next_base;
  logic        next_ok;
  logic [8:0]  next_idx;
  logic        fin;
  logic [1:0]  fin_status;
  logic [1:0]  fin_size;
  logic [29:0] fin_offset;
  logic [52:0] fin_sum;

  ptw_ram #(
    .WIDTH (64),
    .DEPTH (TABLE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign clearing = state == BK_CLEAR;
  assign out_free = !out_valid || !out_stall;

  // A table fits only if all of its 512 words lie inside the store.
  assign root_ok   = root_base <= 36'(MAX_BASE);
  assign next_base = ram_rdata[47:12];
  assign next_ok   = next_base <= 36'(MAX_BASE);

  always_comb begin
    unique case (level)
      LVL_PML4: next_idx = va[38:30];
      LVL_PDPT: next_idx = va[29:21];
      LVL_PD:   next_idx = va[20:12];
      LVL_PT:   next_idx = va[20:12];
      default:  next_idx = va[20:12];
    endcase
  end

  // Decode the entry just read.
  always_comb begin
    fin        = 1'b0;
    fin_status = ST_MAPPED;
    fin_size   = PS_4K;
    fin_offset = '0;
    priority if (!ram_rdata[BIT_PRESENT]) begin
      fin        = 1'b1;
      fin_status = ST_NOT_PRESENT;
    end else if (level == LVL_PDPT && ram_rdata[BIT_LARGE]) begin
      fin        = 1'b1;
      fin_size   = PS_1G;
      fin_offset = va[29:0];
    end else if (level == LVL_PD && ram_rdata[BIT_LARGE]) begin
      fin        = 1'b1;
      fin_size   = PS_2M;
      fin_offset = {9'd0, va[20:0]};
    end else if (level == LVL_PT) begin
      fin        = 1'b1;
      fin_offset = {18'd0, va[11:0]};
    end else if (!next_ok) begin
      fin        = 1'b1;
      fin_status = ST_OUT_OF_RANGE;
    end else begin
      fin = 1'b0;
    end
  end

  assign fin_sum = 53'({ram_rdata[47:12], 12'd0}) + 53'(fin_offset);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      BK_CLEAR: begin
        if (clr_cnt == AW'(TABLE_WORDS - 1)) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (head_valid && head.cmd == CMD_WALK && root_ok) begin
          state_next = BK_EVAL;
        end
      end
      BK_EVAL: begin
        if (fin && out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_CLEAR;
    endcase
  end

  // Outputs: store port, queue pop, result slot.
  always_comb begin
    pop        = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = AW'(head.index);
    ram_wdata  = head.data;
    ram_re     = 1'b0;
    ram_raddr  = AW'({next_base, next_idx});
    level_next = level;
    va_load    = 1'b0;
    out_load   = 1'b0;
    out_next   = '0;
    unique case (state)
      BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
      end
      BK_IDLE: begin
        if (head_valid) begin
          if (head.cmd == CMD_WRITE) begin
            pop    = 1'b1;
            ram_we = 1'b1;
          end else if (root_ok) begin
            pop        = 1'b1;
            ram_re     = 1'b1;
            ram_raddr  = AW'({root_base, head.data[47:39]});
            level_next = LVL_PML4;
            va_load    = 1'b1;
          end else if (out_free) begin
            // Root table beyond the store: fault without a read.
            pop             = 1'b1;
            out_load        = 1'b1;
            out_next.status = ST_OUT_OF_RANGE;
          end
        end
      end
      BK_EVAL: begin
        if (fin) begin
          if (out_free) begin
            out_load           = 1'b1;
            out_next.status    = fin_status;
            out_next.page_size = (fin_status == ST_MAPPED) ? fin_size : PS_4K;
            out_next.phys_addr = (fin_status == ST_MAPPED) ? fin_sum : '0;
          end
        end else begin
          ram_re     = 1'b1;
          level_next = level + 2'd1;
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      clr_cnt   <= '0;
      level     <= LVL_PML4;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      level <= level_next;
      if (state == BK_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (va_load) begin
      va <= head.data[47:0];
    end
    if (out_load) begin
      out_word <= out_next;
    end
  end

  `PTW_NEVER(a_no_cmd_while_clear, clearing && (pop || ram_re), "command taken during clear")
  `PTW_ASSERT(a_level_advance, (state == BK_EVAL && ram_re) |=> (level == $past(level) + 2'd1), "walk level did not advance")
  `PTW_ASSERT(a_fault_zero, (out_load && out_next.status != ST_MAPPED) |-> (out_next.phys_addr == '0 && out_next.page_size == PS_4K), "fault result carries an address")
  `PTW_NEVER(a_load_full, out_load && out_valid && out_stall, "result slot overwritten")

endmodule

FILE: hw/rtl/page_table_walk.sv
// ----------------------------------------------------------------------------
// page_table_walk: four-level page table walker with an internal table store
// Write words (mode 0) store one 64-bit entry; translate words (mode 1) walk
// PML4, PDPT, PD and PT starting from the root table register and give one result.
// After reset the store is cleared to zero, one entry a cycle; while it
// clears, in_stall stays high (configuration writes still land). The
// execution side applies a write straight from the queue head. A translation
// issues the root read and then one read per level, in order, since the store
// has a single read port and each level depends on the previous entry. A
// two-word queue sits between the input side and the walker, so one or two
// words can be taken while a walk is in flight, and a finished result waits
// in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_table_walk
  import ptw_pkg::*;
#(
  parameter int unsigned TABLE_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: root table register
  input  logic        cfg_we,
  input  logic [51:0] cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word
);

  // Only bits 47:12 of the root address matter: keep just those.
  logic [35:0] root_base;

  logic      q_full;
  logic      q_push;
  q_entry_t  q_push_entry;
  logic      q_pop;
  logic      q_head_valid;
  q_entry_t  q_head;
  logic      clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_base <= '0;
    end else if (cfg_we) begin
      root_base <= cfg_wdata[47:12];
    end
  end

  // Front: accept and classify; drop writes beyond the store.
  ptw_front #(
    .TABLE_WORDS (TABLE_WORDS)
  ) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .q_full     (q_full),
    .clearing   (clearing),
    .push       (q_push),
    .push_entry (q_push_entry)
  );

  // Decouple the two sides.
  ptw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // Back: clear, write, walk, deliver.
  ptw_back #(
    .TABLE_WORDS (TABLE_WORDS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .root_base  (root_base),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .clearing   (clearing),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

endmodule

FILE: tb/page_table_walk_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_walk_tb: self-checking bench for the four-level page table walker
// Build page tables in the block's store with write words, then translate
// addresses through them. A scoreboard keeps its own copy of the store and the
// root register, predicts each walk, and checks every result word in order.
// Phases change the root register and the idle pattern on both channels.
// ----------------------------------------------------------------------------

module page_table_walk_tb;
  import ptw_pkg::*;

  localparam int unsigned TABLE_WORDS   = 4096;
  localparam logic [63:0] BASE_MASK     = 64'h0000_FFFF_FFFF_F000;
  // Margin for a walk to finish, plus the two-word queue and the output register.
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES   = 300;
  // Store clear after reset, ~1100 words at the slowest idle mix, many times over.
  localparam int unsigned CYCLE_LIMIT   = 400000;

  // --------------------------------------------------------------------------
  // Scoreboard: mirror of the table store and root register, predicted
  // translations waiting for their result words.
  // --------------------------------------------------------------------------
  class walk_scoreboard;
    logic [63:0] tbl_mem [TABLE_WORDS];
    logic [51:0] root_addr;
    out_word_t   expected_xlat [$];
    int          errors;

    function new();
      foreach (tbl_mem[i]) tbl_mem[i] = '0;
      root_addr = '0;
      errors    = 0;
    endfunction

    // Walk PML4, PDPT, PD, PT against the mirrored store.
    function out_word_t predict_walk(logic [63:0] va);
      int          lvl;
      logic [8:0]  idx;
      logic [63:0] base, first, word, phys;
      out_word_t   res;
      res  = '0;
      base = {12'b0, root_addr} & BASE_MASK;
      for (lvl = 0; lvl < 4; lvl++) begin
        idx   = va[39 - 9 * lvl +: 9];
        first = base >> 3;
        // The whole 512-word table must fit in the store.
        if (first > TABLE_WORDS - WORDS_PER_TABLE) begin
          res.status = ST_OUT_OF_RANGE;
          return res;
        end
        word = tbl_mem[(first + idx) % TABLE_WORDS];
        if (!word[BIT_PRESENT]) begin
          res.status = ST_NOT_PRESENT;
          return res;
        end
        phys = word & BASE_MASK;
        if (lvl == LVL_PDPT && word[BIT_LARGE]) begin
          res.phys_addr = 53'(phys + va[29:0]);
          res.page_size = PS_1G;
          return res;
        end
        if (lvl == LVL_PD && word[BIT_LARGE]) begin
          res.phys_addr = 53'(phys + va[20:0]);
          res.page_size = PS_2M;
          return res;
        end
        if (lvl == LVL_PT) begin
          res.phys_addr = 53'(phys + va[11:0]);
          res.page_size = PS_4K;
          return res;
        end
        base = phys;
      end
      return res;
    endfunction

    // Record an accepted input word.
    function void note_word(in_word_t w);
      if (w.mode == MODE_WRITE) begin
        if (w.entry_index < TABLE_WORDS) tbl_mem[w.entry_index] = w.entry_value;
      end else begin
        expected_xlat.push_back(predict_walk(w.virt_addr));
      end
    endfunction

    // Compare an accepted result word with the oldest prediction.
    function void check_result(out_word_t r);
      out_word_t e;
      if (expected_xlat.size() == 0) begin
        $error("unexpected result: phys_addr=%h status=%0d page_size=%0d",
               r.phys_addr, r.status, r.page_size);
        errors++;
        return;
      end
      e = expected_xlat.pop_front();
      if (r.phys_addr !== e.phys_addr) begin
        $error("phys_addr: expected %h, actual %h", e.phys_addr, r.phys_addr);
        errors++;
      end
      if (r.status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, r.status);
        errors++;
      end
      if (r.page_size !== e.page_size) begin
        $error("page_size: expected %0d, actual %0d", e.page_size, r.page_size);
        errors++;
      end
    endfunction

    function int pending();
      return expected_xlat.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block hookup; every input starts at a known value.
  // --------------------------------------------------------------------------
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [51:0] cfg_wdata = '0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_word_t    in_word   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;

  int          sender_idle_pct = 0;
  int          stall_pct       = 0;
  int          hold_left       = 0;
  int unsigned cycle_count     = 0;

  walk_scoreboard xlat_sb = new();

  page_table_walk #(
    .TABLE_WORDS(TABLE_WORDS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always #6 clk = ~clk;

  // Sample result words at the rising edge; bound the run length.
  always @(posedge clk) begin
    cycle_count++;
    if (!rst && out_valid && !out_stall) xlat_sb.check_result(out_word);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("page_table_walk_tb: errors");
      $finish;
    end
  end

  // Receiver: hold off for a counted stretch when asked, else stall at random.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Favor the low slots and the last slot so walks hit entries already written.
  function automatic logic [8:0] pick_slot();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 9'($urandom_range(0, 3));
    if (r < 80) return 9'd511;
    return 9'($urandom_range(0, 511));
  endfunction

  // Mostly present pointers to one of the eight tables, or to the first table
  // just past the store; some not present, some raw noise.
  function automatic logic [63:0] random_entry();
    logic [63:0] v;
    logic [3:0]  t;
    int          r;
    v = {$urandom, $urandom};
    t = 4'($urandom_range(0, 8));
    r = $urandom_range(0, 99);
    if (r < 60) begin
      v[47:12]       = 36'(t);
      v[BIT_PRESENT] = 1'b1;
      v[BIT_LARGE]   = ($urandom_range(0, 3) == 0);
    end else if (r < 72) begin
      v[BIT_PRESENT] = 1'b0;
    end
    return v;
  endfunction

  function automatic logic [63:0] random_va();
    if ($urandom_range(0, 99) < 5) return {$urandom, $urandom};
    return {16'($urandom), pick_slot(), pick_slot(), pick_slot(), pick_slot(),
            12'($urandom)};
  endfunction

  // Unused fields carry noise; the block must ignore them.
  function automatic in_word_t write_item(logic [11:0] idx, logic [63:0] val);
    in_word_t w;
    w.mode        = MODE_WRITE;
    w.entry_index = idx;
    w.entry_value = val;
    w.virt_addr   = {$urandom, $urandom};
    return w;
  endfunction

  function automatic in_word_t walk_item(logic [63:0] va);
    in_word_t w;
    w.mode        = MODE_WALK;
    w.entry_index = 12'($urandom);
    w.entry_value = {$urandom, $urandom};
    w.virt_addr   = va;
    return w;
  endfunction

  // Offer one word from the falling edge, with random idle cycles first;
  // hold it until the rising edge that takes it.
  task automatic send_word(in_word_t w);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    xlat_sb.note_word(w);
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (xlat_sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_root(logic [51:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    xlat_sb.root_addr = v;
  endtask

  // Drain the block, let trailing writes land, then switch the setup.
  task automatic new_phase(logic [51:0] root, int idle_pct, int stall);
    go_quiet();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_root(root);
    sender_idle_pct = idle_pct;
    stall_pct       = stall;
  endtask

  task automatic run_random(int count);
    repeat (count) begin
      if ($urandom_range(0, 99) < 55)
        send_word(walk_item(random_va()));
      else
        send_word(write_item({3'($urandom_range(0, 7)), pick_slot()}, random_entry()));
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: root at word 0; PML4 in table 0, PDPT table 1, PD table 2,
    // PT table 3. The store clear after reset holds off the first word.
    write_root(52'h0);
    send_word(walk_item(64'h0));                                   // empty PML4
    // PML4 entry with the page-size bit set: still names a PDPT.
    send_word(write_item(12'd0, 64'h0000_0000_0000_1081));
    send_word(walk_item(64'h0000_0000_0000_0123));                 // PDPT absent
    send_word(write_item(12'd512, 64'h0000_0000_0000_2003));
    send_word(write_item(12'd1024, 64'h0000_0000_0000_3001));
    send_word(walk_item(64'h0000_0000_0000_0456));                 // PT absent
    // PT entry with every bit set: page-size bit ignored, top base.
    send_word(write_item(12'd1536, 64'hFFFF_FFFF_FFFF_FFFF));
    // Upper address bits set: no canonical check.
    send_word(walk_item(64'hFFFF_0000_0000_0FFF));
    // 2 MiB page, base low bits kept, offset carries into bit 48.
    send_word(write_item(12'd1025, 64'h0000_FFFF_FFFF_F081));
    send_word(walk_item(64'h0000_0000_003F_FFFF));
    // 1 GiB page.
    send_word(write_item(12'd513, 64'h8000_0000_4000_0081));
    send_word(walk_item(64'h0000_0000_7FFF_FFFF));
    // PD table just past the end of the store.
    send_word(write_item(12'd514, 64'h0000_0000_0000_8001));
    send_word(walk_item(64'h0000_0000_8000_0000));
    // Last PML4 slot to the last table; last store word as a 1 GiB page
    // with the top base, so the offset carries.
    send_word(write_item(12'd511, 64'h0000_0000_0000_7001));
    send_word(write_item(12'd4095, 64'hFFFF_FFFF_FFFF_FFFF));
    send_word(walk_item(64'h0000_FFFF_FFFF_FFFF));
    // Page-size bit without the present bit: not present.
    send_word(write_item(12'd1026, 64'h0000_0000_0000_0080));
    send_word(walk_item(64'h0000_0000_0040_0000));
    send_word(write_item(12'd1537, 64'h0000_0000_0000_0001));
    send_word(walk_item(64'h0000_0000_0000_1ABC));                 // 4 KiB, base 0

    // No idling; the receiver holds off long enough to back up the input,
    // then the sender pauses until every result is out.
    new_phase(52'hA_0000_0000_3ABC, 0, 0);
    hold_left = HOLD_CYCLES;
    run_random(100);
    go_quiet();
    wait_drained();
    run_random(100);

    // Highest table that fits, sender mostly idle.
    new_phase(52'h0_0000_0000_7000, 80, 0);
    run_random(200);

    // Root low bits set and ignored, receiver mostly stalling.
    new_phase(52'h0_0000_0000_0FFF, 0, 80);
    run_random(200);

    // Root far outside the store: every walk is out of range.
    new_phase(52'hF_FFFF_FFFF_F000, 26, 26);
    run_random(40);

    new_phase(52'h0_0000_0000_1000, 26, 26);
    run_random(200);

    new_phase(52'h5_0000_0000_5000, 26, 26);
    run_random(200);

    go_quiet();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (xlat_sb.errors == 0) begin
      $display("page_table_walk_tb: clean");
    end else begin
      $display("page_table_walk_tb: errors");
    end
    $finish;
  end

endmodule

FILE: page_table_walk.f
+incdir+hw/rtl
hw/rtl/ptw_pkg.sv
hw/rtl/ptw_ram.sv
hw/rtl/ptw_front.sv
hw/rtl/ptw_queue.sv
hw/rtl/ptw_back.sv
hw/rtl/page_table_walk.sv
tb/page_table_walk_tb.sv
